@@ rtl/radial_gradient_subtractive_paint_assert.svh @@
// Assertion macros shared by the radial gradient paint RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef RADIAL_GRADIENT_SUBTRACTIVE_PAINT_ASSERT_SVH
`define RADIAL_GRADIENT_SUBTRACTIVE_PAINT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RGSP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgsp check failed");

// Next-cycle implication, disabled during reset.
`define RGSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgsp check failed");

`endif

@@ rtl/rgsp_pkg.sv @@
// Types and constants for the radial gradient paint pipeline.
// No dependencies; imported by every rgsp module and the top level.
`timescale 1ns / 1ps

package rgsp_pkg;

   localparam int COORD_BITS  = 12;
   localparam int PIX_COORD_W = COORD_BITS;
   localparam int COLOR_W     = 16;
   localparam int INV_W       = 32;
   localparam int FRAC_W      = 16;
   localparam int RATE_W      = FRAC_W + 1;
   localparam int D2_W        = 2 * PIX_COORD_W + 1;
   localparam int PROD_W      = D2_W + INV_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1 << FRAC_W);

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RADIUS_SQ = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAD_RED      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAD_GREEN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAD_BLUE     = 3'd6;

   typedef struct packed {
      logic [PIX_COORD_W-1:0] pix_x;
      logic [PIX_COORD_W-1:0] pix_y;
      logic [COLOR_W-1:0]     in_red;
      logic [COLOR_W-1:0]     in_green;
      logic [COLOR_W-1:0]     in_blue;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] out_red;
      logic [COLOR_W-1:0] out_green;
      logic [COLOR_W-1:0] out_blue;
      logic               inside_res;
   } rsp_type;

   typedef struct packed {
      logic [PIX_COORD_W-1:0] center_x;
      logic [PIX_COORD_W-1:0] center_y;
      logic [PIX_COORD_W-1:0] radius;
      logic [INV_W-1:0]       inv_radius_sq;
      logic [COLOR_W-1:0]     grad_red;
      logic [COLOR_W-1:0]     grad_green;
      logic [COLOR_W-1:0]     grad_blue;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      center_x:      '0,
      center_y:      '0,
      radius:        PIX_COORD_W'(1),
      inv_radius_sq: '1,
      grad_red:      '0,
      grad_green:    '0,
      grad_blue:     '0
   };

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

   // Distance stage output: squared distance and inside flag.
   typedef struct packed {
      logic            valid;
      logic [D2_W-1:0] d2;
      logic            in_disc;
      color_type       color;
   } geom_type;

   // Weight stage output: rate in Q1.16, 1.0 = RATE_ONE.
   typedef struct packed {
      logic              valid;
      logic [RATE_W-1:0] rate;
      logic              in_disc;
      color_type         color;
   } rate_type;

endpackage

@@ rtl/rgsp_geom.sv @@
// Stages 1-2: coordinate differences, squared distance and inside test.
// Depends on rgsp_pkg.
`timescale 1ns / 1ps

module rgsp_geom (
   input  logic              clock,
   input  logic              reset,
   input  rgsp_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  rgsp_pkg::req_type in_data,
   output logic              in_ready,
   output rgsp_pkg::geom_type out_stage,
   input  logic              out_ready
);
   import rgsp_pkg::*;

   localparam int CW = COORD_BITS;

   logic [CW-1:0]     px, py, cx, cy, rad;
   logic              s1_ready, s2_ready;
   logic              s1_valid_ff, s2_valid_ff;
   logic [CW-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   color_type         col1_ff, col1_in, col2_ff;
   logic [2*CW-1:0]   rsq_ff, rsq_in;
   logic [2*CW-1:0]   dxsq, dysq;
   logic [2*CW:0]     d2_ff, d2_in;
   logic              inside_ff, inside_in;

   assign px  = in_data.pix_x[CW-1:0];
   assign py  = in_data.pix_y[CW-1:0];
   assign cx  = cfg.center_x[CW-1:0];
   assign cy  = cfg.center_y[CW-1:0];
   assign rad = cfg.radius[CW-1:0];

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      dx_in   = (px >= cx) ? px - cx : cx - px;
      dy_in   = (py >= cy) ? py - cy : cy - py;
      col1_in = '{red: in_data.in_red, green: in_data.in_green, blue: in_data.in_blue};
      rsq_in  = rad * rad;
      dxsq    = dx_ff * dx_ff;
      dysq    = dy_ff * dy_ff;
      d2_in   = {1'b0, dxsq} + {1'b0, dysq};
      inside_in = d2_in <= {1'b0, rsq_ff};
   end

   // radius squared only changes on a register write or a reset
   always_ff @(posedge clock) begin
      rsq_ff <= rsq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         col1_ff <= col1_in;
      end
      if (s2_ready && s1_valid_ff) begin
         d2_ff     <= d2_in;
         inside_ff <= inside_in;
         col2_ff   <= col1_ff;
      end
   end

   assign out_stage = '{
      valid:   s2_valid_ff,
      d2:      D2_W'(d2_ff),
      in_disc: inside_ff,
      color:   col2_ff
   };

endmodule

@@ rtl/rgsp_rate.sv @@
// Stages 3-4: d2 times reciprocal, then saturated weight 1 - d2/r^2.
// Depends on rgsp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "radial_gradient_subtractive_paint_assert.svh"

module rgsp_rate (
   input  logic                clock,
   input  logic                reset,
   input  logic [rgsp_pkg::INV_W-1:0] inv_radius_sq,
   input  rgsp_pkg::geom_type  in_stage,
   output logic                in_ready,
   output rgsp_pkg::rate_type  out_stage,
   input  logic                out_ready
);
   import rgsp_pkg::*;

   localparam int QW = PROD_W - FRAC_W;

   logic              s3_ready, s4_ready;
   logic              s3_valid_ff, s4_valid_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              ins3_ff, ins4_ff;
   color_type         col3_ff, col4_ff;
   logic [QW-1:0]     q;
   logic [RATE_W-1:0] rate_ff, rate_in;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   always_comb begin
      prod_in = in_stage.d2 * inv_radius_sq;
      q       = prod_ff[PROD_W-1:FRAC_W];
      // a q of 1.0 or more gives zero weight, so the weight bottoms out at zero
      rate_in = (q > QW'(RATE_ONE)) ? '0 : RATE_ONE - q[RATE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) s3_valid_ff <= in_stage.valid;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_stage.valid) begin
         prod_ff <= prod_in;
         ins3_ff <= in_stage.in_disc;
         col3_ff <= in_stage.color;
      end
      if (s4_ready && s3_valid_ff) begin
         rate_ff <= rate_in;
         ins4_ff <= ins3_ff;
         col4_ff <= col3_ff;
      end
   end

   assign out_stage = '{valid: s4_valid_ff, rate: rate_ff, in_disc: ins4_ff, color: col4_ff};

   `RGSP_ASSERT_IMPLY(a_rate_le_one, clock, reset, s4_valid_ff, rate_ff <= RATE_ONE)

endmodule

@@ rtl/rgsp_blend.sv @@
// Stages 5-6: weighted gradient channels and saturating subtract.
// Depends on rgsp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "radial_gradient_subtractive_paint_assert.svh"

module rgsp_blend (
   input  logic               clock,
   input  logic               reset,
   input  rgsp_pkg::cfg_type  cfg,
   input  rgsp_pkg::rate_type in_stage,
   output logic               in_ready,
   output logic               out_valid,
   output rgsp_pkg::rsp_type  out_data,
   input  logic               out_ready
);
   import rgsp_pkg::*;

   localparam int WP_W = COLOR_W + RATE_W;

   function automatic logic [COLOR_W-1:0] sub_sat(input logic [COLOR_W-1:0] c,
                                                  input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
      logic [COLOR_W:0] loss;
      loss = {1'b0, a} + {1'b0, b};
      if (loss >= {1'b0, c}) return '0;
      return c - loss[COLOR_W-1:0];
   endfunction

   logic               s5_ready, s6_ready;
   logic               s5_valid_ff, s6_valid_ff;
   logic [WP_W-1:0]    pr, pg, pb;
   logic [COLOR_W-1:0] wr_ff, wr_in, wg_ff, wg_in, wb_ff, wb_in;
   logic               ins5_ff;
   color_type          col5_ff;
   rsp_type            res_ff, res_in;

   assign s6_ready = !s6_valid_ff || out_ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign in_ready = s5_ready;

   always_comb begin
      pr    = cfg.grad_red   * in_stage.rate;
      pg    = cfg.grad_green * in_stage.rate;
      pb    = cfg.grad_blue  * in_stage.rate;
      wr_in = pr[FRAC_W +: COLOR_W];
      wg_in = pg[FRAC_W +: COLOR_W];
      wb_in = pb[FRAC_W +: COLOR_W];
      if (ins5_ff) begin
         res_in = '{out_red:   sub_sat(col5_ff.red,   wg_ff, wb_ff),
                    out_green: sub_sat(col5_ff.green, wr_ff, wb_ff),
                    out_blue:  sub_sat(col5_ff.blue,  wr_ff, wg_ff),
                    inside_res: 1'b1};
      end else begin
         res_in = '{out_red: col5_ff.red, out_green: col5_ff.green,
                    out_blue: col5_ff.blue, inside_res: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (s5_ready) s5_valid_ff <= in_stage.valid;
         if (s6_ready) s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready && in_stage.valid) begin
         wr_ff   <= wr_in;
         wg_ff   <= wg_in;
         wb_ff   <= wb_in;
         ins5_ff <= in_stage.in_disc;
         col5_ff <= in_stage.color;
      end
      if (s6_ready && s5_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_data  = res_ff;

   // zero weight, or an outside pixel, must leave the color untouched
   `RGSP_ASSERT_NEXT(a_zero_weight_passes, clock, reset,
      s5_valid_ff && s6_ready && (!ins5_ff || (wr_ff == '0 && wg_ff == '0 && wb_ff == '0)),
      res_ff.out_red == $past(col5_ff.red) &&
      res_ff.out_green == $past(col5_ff.green) &&
      res_ff.out_blue == $past(col5_ff.blue))

endmodule

@@ rtl/radial_gradient_subtractive_paint.sv @@
// Radial gradient subtractive paint: top level, register file and pipeline.
// Depends on rgsp_pkg, rgsp_geom, rgsp_rate, rgsp_blend and the assertion header.
`timescale 1ns / 1ps
`include "radial_gradient_subtractive_paint_assert.svh"

// Usage
//  req_ carries one pixel (coordinates and RGB); a transfer happens on an edge
//  with req_valid high and req_stall low. rsp_ returns one painted pixel per
//  request, in order, under the same valid/stall rule.
//  csr_ writes one of seven registers (center, radius, reciprocal of radius
//  squared, gradient RGB). csr_ready is always high; write only while no
//  pixel is in flight. Unknown indexes are dropped.
// Timing
//  Six register stages: abs diff, squared distance and inside test, d2 times
//  reciprocal, weight, gradient weighting, saturating subtract. Throughput is
//  one pixel per clock while rsp_stall is low; pixels share no state.
// Reset and stall
//  Reset clears all stage valids and loads the register defaults (radius 1,
//  reciprocal all ones, everything else zero).
//  rsp_stall holds the output stage; upstream stages keep filling empty slots,
//  so req_stall rises only once every stage holds a pixel.
module radial_gradient_subtractive_paint (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rgsp_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rgsp_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rgsp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rgsp_pkg::CSR_DATA_W-1:0]       csr_data
);
   import rgsp_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   geom_type geom_stage;
   rate_type rate_stage;
   logic     geom_ready, rate_ready, blend_ready;

   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CENTER_X:      cfg_in.center_x      = csr_data[PIX_COORD_W-1:0];
            CSR_CENTER_Y:      cfg_in.center_y      = csr_data[PIX_COORD_W-1:0];
            CSR_RADIUS:        cfg_in.radius        = csr_data[PIX_COORD_W-1:0];
            CSR_INV_RADIUS_SQ: cfg_in.inv_radius_sq = csr_data[INV_W-1:0];
            CSR_GRAD_RED:      cfg_in.grad_red      = csr_data[COLOR_W-1:0];
            CSR_GRAD_GREEN:    cfg_in.grad_green    = csr_data[COLOR_W-1:0];
            CSR_GRAD_BLUE:     cfg_in.grad_blue     = csr_data[COLOR_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline: each stage loads when it is empty or its successor moves
   rgsp_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (geom_ready),
      .out_stage (geom_stage),
      .out_ready (rate_ready)
   );

   rgsp_rate u_rate (
      .clock         (clock),
      .reset         (reset),
      .inv_radius_sq (cfg_ff.inv_radius_sq),
      .in_stage      (geom_stage),
      .in_ready      (rate_ready),
      .out_stage     (rate_stage),
      .out_ready     (blend_ready)
   );

   rgsp_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_stage  (rate_stage),
      .in_ready  (blend_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (!rsp_stall)
   );

   assign req_stall = !geom_ready;

   // an open output lets every stage move, so the input never stalls
   `RGSP_ASSERT_IMPLY(a_no_stall_when_drained, clock, reset, !rsp_stall, !req_stall)
   // the pipeline comes out of reset empty
   `RGSP_ASSERT_IMPLY(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)
   // a full input side means the output side is blocked
   `RGSP_ASSERT_IMPLY(a_stall_needs_block, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule
